/* rtl/llp_pkg.sv */
// ----------------------------------------------------------------------------
// llp_pkg
// Shared constants, operation and status codes, and transaction types of the
// linked list pool engine.
// ----------------------------------------------------------------------------
package llp_pkg;

	localparam int DEF_NUM_HEADS  = 8;
	localparam int DEF_NUM_NODES  = 64;
	localparam int DEF_ITEM_WIDTH = 32;

	localparam int OPCODE_W = 4;
	localparam int HANDLE_W = 3;
	localparam int ITEM_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [OPCODE_W-1:0] OP_CREATE     = 4'd0;
	localparam logic [OPCODE_W-1:0] OP_COUNT      = 4'd1;
	localparam logic [OPCODE_W-1:0] OP_FIRST      = 4'd2;
	localparam logic [OPCODE_W-1:0] OP_LAST       = 4'd3;
	localparam logic [OPCODE_W-1:0] OP_NEXT       = 4'd4;
	localparam logic [OPCODE_W-1:0] OP_PREV       = 4'd5;
	localparam logic [OPCODE_W-1:0] OP_CURRENT    = 4'd6;
	localparam logic [OPCODE_W-1:0] OP_INS_AFTER  = 4'd7;
	localparam logic [OPCODE_W-1:0] OP_INS_BEFORE = 4'd8;
	localparam logic [OPCODE_W-1:0] OP_APPEND     = 4'd9;
	localparam logic [OPCODE_W-1:0] OP_PREPEND    = 4'd10;
	localparam logic [OPCODE_W-1:0] OP_REMOVE     = 4'd11;
	localparam logic [OPCODE_W-1:0] OP_TRIM       = 4'd12;
	localparam logic [OPCODE_W-1:0] OP_CONCAT     = 4'd13;
	localparam logic [OPCODE_W-1:0] OP_FREE       = 4'd14;
	localparam logic [OPCODE_W-1:0] OP_SEARCH     = 4'd15;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

	// insert position
	localparam logic [1:0] WH_APPEND  = 2'd0;
	localparam logic [1:0] WH_PREPEND = 2'd1;
	localparam logic [1:0] WH_AFTER   = 2'd2;
	localparam logic [1:0] WH_BEFORE  = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [HANDLE_W-1:0] list_sel;
		logic [HANDLE_W-1:0] second_list;
		logic [ITEM_W-1:0]   item_value;
	} llp_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ITEM_W-1:0]   item_out;
		logic                item_valid;
		logic [COUNT_W-1:0]  count_out;
		logic [HANDLE_W-1:0] new_list;
	} llp_result_t;

endpackage

/* rtl/llp_cmd_if.sv */
// ----------------------------------------------------------------------------
// llp_cmd_if
// Command channel: valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface llp_cmd_if import llp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [HANDLE_W-1:0] list_sel;
	logic [HANDLE_W-1:0] second_list;
	logic [ITEM_W-1:0]   item_value;

	modport source (output valid, opcode, list_sel, second_list, item_value, input ready);
	modport sink (input valid, opcode, list_sel, second_list, item_value, output ready);
endinterface

/* rtl/llp_res_if.sv */
// ----------------------------------------------------------------------------
// llp_res_if
// Result channel: valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface llp_res_if import llp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ITEM_W-1:0]   item_out;
	logic                item_valid;
	logic [COUNT_W-1:0]  count_out;
	logic [HANDLE_W-1:0] new_list;

	modport source (output valid, status, item_out, item_valid, count_out, new_list,
		input ready);
	modport sink (input valid, status, item_out, item_valid, count_out, new_list,
		output ready);
endinterface

/* rtl/llp_ram.sv */
// ----------------------------------------------------------------------------
// llp_ram
// Single port RAM with registered read data, no reset.
// ----------------------------------------------------------------------------
module llp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/llp_core.sv */
// ----------------------------------------------------------------------------
// llp_core
// Sequencer over the node RAMs, list table and free node stack.
// ----------------------------------------------------------------------------
module llp_core import llp_pkg::*; #(
	parameter int NUM_HEADS  = DEF_NUM_HEADS,
	parameter int NUM_NODES  = DEF_NUM_NODES,
	parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  llp_cmd_t    cmd,
	output logic        idle,
	output logic        done,
	input  logic        done_ack,
	output llp_result_t result
);
	localparam int NW  = $clog2(NUM_NODES + 3);
	localparam int AW  = $clog2(NUM_NODES);
	localparam int LW  = $clog2(NUM_NODES + 1);
	localparam int HIW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
	localparam logic [NW-1:0] NIL    = NW'(NUM_NODES);
	localparam logic [NW-1:0] BEFORE = NW'(NUM_NODES + 1);
	localparam logic [NW-1:0] BEYOND = NW'(NUM_NODES + 2);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_LOAD    = 5'd1;
	localparam logic [4:0] S_EXEC    = 5'd2;
	localparam logic [4:0] S_NAV     = 5'd3;
	localparam logic [4:0] S_FETCH   = 5'd4;
	localparam logic [4:0] S_FETCH_W = 5'd5;
	localparam logic [4:0] S_INS_W   = 5'd6;
	localparam logic [4:0] S_GRAB    = 5'd7;
	localparam logic [4:0] S_GRAB_W  = 5'd8;
	localparam logic [4:0] S_SPL1    = 5'd9;
	localparam logic [4:0] S_SPL2    = 5'd10;
	localparam logic [4:0] S_RM_W    = 5'd11;
	localparam logic [4:0] S_RM_WR   = 5'd12;
	localparam logic [4:0] S_TR_W    = 5'd13;
	localparam logic [4:0] S_TR_WR   = 5'd14;
	localparam logic [4:0] S_GIVE    = 5'd15;
	localparam logic [4:0] S_CC_LD   = 5'd16;
	localparam logic [4:0] S_CC_JOIN = 5'd17;
	localparam logic [4:0] S_FR_RD   = 5'd18;
	localparam logic [4:0] S_FR_W    = 5'd19;
	localparam logic [4:0] S_SR_RD   = 5'd20;
	localparam logic [4:0] S_SR_W    = 5'd21;
	localparam logic [4:0] S_DONE    = 5'd22;

	logic [4:0] state_q;

	// list table
	logic [NW-1:0] head_q [NUM_HEADS];
	logic [NW-1:0] tail_q [NUM_HEADS];
	logic [NW-1:0] cur_q  [NUM_HEADS];
	logic [LW-1:0] len_q  [NUM_HEADS];
	logic [NUM_HEADS-1:0] use_q;

	logic [NW-1:0] fhead_q;
	logic [LW-1:0] fresh_q;

	// working copy of one command and of its list's table entry
	logic [OPCODE_W-1:0]   op_q;
	logic [HANDLE_W-1:0]   h_q;
	logic [HANDLE_W-1:0]   s_q;
	logic [ITEM_WIDTH-1:0] v_q;
	logic                  hok_q;
	logic [NW-1:0]         lh_q, lt_q, lc_q;
	logic [LW-1:0]         ll_q;
	logic [NW-1:0]         p_q, f_q, n_q, g_q;
	logic [NW-1:0]         sh_q, stl_q;
	logic [LW-1:0]         sl_q;
	logic [1:0]            where_q;

	logic [STATUS_W-1:0]   rst_q;
	logic [ITEM_WIDTH-1:0] ritem_q;
	logic                  rval_q;
	logic [HANDLE_W-1:0]   rnew_q;

	// node RAM ports
	logic                  i_we, f_we, b_we;
	logic [AW-1:0]         i_addr, f_addr, b_addr;
	logic [ITEM_WIDTH-1:0] i_wd, i_rd;
	logic [NW-1:0]         f_wd, f_rd, b_wd, b_rd;

	logic                  free_found;
	logic [HIW-1:0]        free_idx;
	logic [HIW-1:0]        hidx, sidx;
	logic                  ins_op, ins_bad;
	logic [1:0]            ins_where;
	logic [NW-1:0]         nav_n;

	function automatic logic is_node(input logic [NW-1:0] x);
		return x < NIL;
	endfunction

	function automatic logic [AW-1:0] na(input logic [NW-1:0] x);
		return x[AW-1:0];
	endfunction

	llp_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(NUM_NODES)) u_item (
		.clk(clk), .we(i_we), .addr(i_addr), .wdata(i_wd), .rdata(i_rd));
	llp_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_fwd (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));
	llp_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_bwd (
		.clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));

	assign hidx = HIW'(h_q);
	assign sidx = HIW'(s_q);

	// lowest handle not in use
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = NUM_HEADS - 1; k >= 0; k--) begin
			if (!use_q[k]) begin
				free_found = 1'b1;
				free_idx   = HIW'(k);
			end
		end
	end

	// resolve insert position against the cursor
	always_comb begin
		ins_op  = (op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE) ||
			(op_q == OP_APPEND) || (op_q == OP_PREPEND);
		ins_bad = 1'b0;
		case (op_q)
			OP_APPEND:    ins_where = WH_APPEND;
			OP_PREPEND:   ins_where = WH_PREPEND;
			OP_INS_AFTER: ins_where = WH_AFTER;
			default:      ins_where = WH_BEFORE;
		endcase
		if ((op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE)) begin
			if (ll_q == '0 || lc_q == BEYOND) begin
				ins_where = WH_APPEND;
			end else if (lc_q == BEFORE) begin
				ins_where = WH_PREPEND;
			end else if (!is_node(lc_q)) begin
				ins_bad = 1'b1;
			end
		end
	end

	assign nav_n = is_node(lc_q) ? ((op_q == OP_NEXT) ? f_rd : b_rd) : n_q;

	// node RAM access per state
	always_comb begin
		i_we = 1'b0; f_we = 1'b0; b_we = 1'b0;
		i_addr = na(lc_q); f_addr = na(lc_q); b_addr = na(lc_q);
		i_wd = v_q; f_wd = '0; b_wd = '0;
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_TRIM) begin
					i_addr = na(lt_q);
					b_addr = na(lt_q);
				end
			end
			S_FETCH: i_addr = na(lc_q);
			S_GRAB:  f_addr = na(fhead_q);
			S_SPL1: begin
				i_we = 1'b1; i_addr = na(n_q);
				f_we = 1'b1; f_addr = na(n_q); f_wd = f_q;
				b_we = 1'b1; b_addr = na(n_q); b_wd = p_q;
			end
			S_SPL2: begin
				f_we = is_node(p_q); f_addr = na(p_q); f_wd = n_q;
				b_we = is_node(f_q); b_addr = na(f_q); b_wd = n_q;
			end
			S_RM_WR: begin
				f_we = is_node(p_q); f_addr = na(p_q); f_wd = f_q;
				b_we = is_node(f_q); b_addr = na(f_q); b_wd = p_q;
			end
			S_TR_WR: begin
				f_we = 1'b1; f_addr = na(p_q); f_wd = NIL;
			end
			S_GIVE: begin
				f_we = 1'b1; f_addr = na(g_q); f_wd = fhead_q;
			end
			S_CC_JOIN: begin
				if (sl_q != '0 && ll_q != '0 && is_node(lt_q)) begin
					f_we = 1'b1; f_addr = na(lt_q); f_wd = sh_q;
					b_we = is_node(sh_q); b_addr = na(sh_q); b_wd = lt_q;
				end
			end
			S_FR_RD: f_addr = na(n_q);
			S_FR_W: begin
				f_we = 1'b1; f_addr = na(n_q); f_wd = fhead_q;
			end
			S_SR_RD: begin
				i_addr = na(n_q);
				f_addr = na(n_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			use_q   <= '0;
			fhead_q <= NIL;
			fresh_q <= '0;
			for (int k = 0; k < NUM_HEADS; k++) begin
				head_q[k] <= NIL;
				tail_q[k] <= NIL;
				cur_q[k]  <= NIL;
				len_q[k]  <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= cmd.opcode;
						h_q     <= cmd.list_sel;
						s_q     <= cmd.second_list;
						v_q     <= ITEM_WIDTH'(cmd.item_value);
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					hok_q   <= (op_q != OP_CREATE) && (int'(h_q) < NUM_HEADS) && use_q[hidx];
					lh_q    <= head_q[hidx];
					lt_q    <= tail_q[hidx];
					lc_q    <= cur_q[hidx];
					ll_q    <= len_q[hidx];
					rst_q   <= ST_OK;
					rval_q  <= 1'b0;
					ritem_q <= '0;
					rnew_q  <= '0;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_DONE;
					if (op_q == OP_CREATE) begin
						if (free_found) begin
							use_q[free_idx]  <= 1'b1;
							head_q[free_idx] <= NIL;
							tail_q[free_idx] <= NIL;
							cur_q[free_idx]  <= NIL;
							len_q[free_idx]  <= '0;
							rnew_q           <= HANDLE_W'(free_idx);
						end else begin
							rst_q <= ST_NONE;
						end
					end else if (!hok_q) begin
						rst_q <= ST_NONE;
					end else if (ins_op) begin
						where_q <= ins_where;
						if (ins_bad) begin
							rst_q <= ST_BOUNDS;
						end else begin
							case (ins_where)
								WH_APPEND:  begin p_q <= lt_q; f_q <= NIL; end
								WH_PREPEND: begin p_q <= NIL;  f_q <= lh_q; end
								WH_AFTER:   p_q <= lc_q;
								default:    f_q <= lc_q;
							endcase
							state_q <= S_INS_W;
						end
					end else begin
						case (op_q)
							OP_FIRST, OP_LAST: begin
								if (ll_q == '0) begin
									lc_q  <= NIL;
									rst_q <= ST_BOUNDS;
								end else begin
									lc_q    <= (op_q == OP_FIRST) ? lh_q : lt_q;
									state_q <= S_FETCH;
								end
							end
							OP_NEXT, OP_PREV: begin
								if (is_node(lc_q)) begin
									state_q <= S_NAV;
								end else if (op_q == OP_NEXT && lc_q == BEFORE) begin
									n_q     <= lh_q;
									state_q <= S_NAV;
								end else if (op_q == OP_PREV && lc_q == BEYOND) begin
									n_q     <= lt_q;
									state_q <= S_NAV;
								end else begin
									rst_q <= ST_BOUNDS;
								end
							end
							OP_CURRENT: begin
								if (is_node(lc_q)) begin
									state_q <= S_FETCH;
								end else begin
									rst_q <= ST_BOUNDS;
								end
							end
							OP_REMOVE: begin
								if (is_node(lc_q)) begin
									g_q     <= lc_q;
									state_q <= S_RM_W;
								end else begin
									rst_q <= ST_BOUNDS;
								end
							end
							OP_TRIM: begin
								if (ll_q == '0 || !is_node(lt_q)) begin
									rst_q <= ST_BOUNDS;
								end else begin
									g_q     <= lt_q;
									state_q <= S_TR_W;
								end
							end
							OP_CONCAT: begin
								if (int'(s_q) >= NUM_HEADS || s_q == h_q || !use_q[sidx]) begin
									rst_q <= ST_NONE;
								end else begin
									state_q <= S_CC_LD;
								end
							end
							OP_FREE: begin
								n_q     <= lh_q;
								state_q <= S_FR_RD;
							end
							OP_SEARCH: begin
								if (lc_q == BEFORE || is_node(lc_q)) begin
									n_q     <= (lc_q == BEFORE) ? lh_q : lc_q;
									rst_q   <= ST_BOUNDS;
									state_q <= S_SR_RD;
								end else begin
									rst_q <= ST_BOUNDS;
								end
							end
							default: ;
						endcase
					end
				end
				S_NAV: begin
					if (is_node(nav_n)) begin
						lc_q    <= nav_n;
						state_q <= S_FETCH;
					end else begin
						if (is_node(lc_q)) begin
							lc_q <= (op_q == OP_NEXT) ? BEYOND : BEFORE;
						end
						rst_q   <= ST_BOUNDS;
						state_q <= S_DONE;
					end
				end
				S_FETCH: state_q <= S_FETCH_W;
				S_FETCH_W: begin
					ritem_q <= i_rd;
					rval_q  <= 1'b1;
					state_q <= S_DONE;
				end
				S_INS_W: begin
					if (where_q == WH_AFTER) begin
						f_q <= f_rd;
					end else if (where_q == WH_BEFORE) begin
						p_q <= b_rd;
					end
					state_q <= S_GRAB;
				end
				S_GRAB: begin
					if (is_node(fhead_q)) begin
						n_q     <= fhead_q;
						state_q <= S_GRAB_W;
					end else if (fresh_q < LW'(NUM_NODES)) begin
						n_q     <= NW'(fresh_q);
						fresh_q <= fresh_q + LW'(1);
						state_q <= S_SPL1;
					end else begin
						rst_q   <= ST_NONE;
						state_q <= S_DONE;
					end
				end
				S_GRAB_W: begin
					fhead_q <= f_rd;
					state_q <= S_SPL1;
				end
				S_SPL1: state_q <= S_SPL2;
				S_SPL2: begin
					if (!is_node(p_q)) lh_q <= n_q;
					if (!is_node(f_q)) lt_q <= n_q;
					lc_q    <= n_q;
					ll_q    <= ll_q + LW'(1);
					state_q <= S_DONE;
				end
				S_RM_W: begin
					p_q     <= b_rd;
					f_q     <= f_rd;
					ritem_q <= i_rd;
					rval_q  <= 1'b1;
					state_q <= S_RM_WR;
				end
				S_RM_WR: begin
					if (!is_node(p_q)) lh_q <= f_q;
					if (!is_node(f_q)) lt_q <= p_q;
					if (is_node(f_q)) begin
						lc_q <= f_q;
					end else begin
						lc_q <= (ll_q <= LW'(1)) ? NIL : BEYOND;
					end
					if (ll_q != '0) ll_q <= ll_q - LW'(1);
					state_q <= S_GIVE;
				end
				S_TR_W: begin
					p_q     <= b_rd;
					ritem_q <= i_rd;
					rval_q  <= 1'b1;
					ll_q    <= ll_q - LW'(1);
					if (is_node(b_rd)) begin
						lt_q    <= b_rd;
						lc_q    <= b_rd;
						state_q <= S_TR_WR;
					end else begin
						lh_q    <= NIL;
						lt_q    <= NIL;
						lc_q    <= NIL;
						state_q <= S_GIVE;
					end
				end
				S_TR_WR: state_q <= S_GIVE;
				S_GIVE: begin
					fhead_q <= g_q;
					state_q <= S_DONE;
				end
				S_CC_LD: begin
					sh_q    <= head_q[sidx];
					stl_q   <= tail_q[sidx];
					sl_q    <= len_q[sidx];
					state_q <= S_CC_JOIN;
				end
				S_CC_JOIN: begin
					if (sl_q != '0) begin
						if (ll_q == '0 || !is_node(lt_q)) lh_q <= sh_q;
						lt_q <= stl_q;
						ll_q <= ll_q + sl_q;
					end
					state_q <= S_DONE;
				end
				S_FR_RD: state_q <= is_node(n_q) ? S_FR_W : S_DONE;
				S_FR_W: begin
					fhead_q <= n_q;
					n_q     <= f_rd;
					state_q <= S_FR_RD;
				end
				S_SR_RD: begin
					if (is_node(n_q)) begin
						state_q <= S_SR_W;
					end else begin
						lc_q    <= BEYOND;
						state_q <= S_DONE;
					end
				end
				S_SR_W: begin
					if (i_rd == v_q) begin
						rst_q   <= ST_OK;
						lc_q    <= n_q;
						ritem_q <= i_rd;
						rval_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						n_q     <= f_rd;
						state_q <= S_SR_RD;
					end
				end
				S_DONE: begin
					if (done_ack) begin
						if (hok_q) begin
							if (op_q == OP_FREE) begin
								head_q[hidx] <= NIL;
								tail_q[hidx] <= NIL;
								cur_q[hidx]  <= NIL;
								len_q[hidx]  <= '0;
								use_q[hidx]  <= 1'b0;
							end else begin
								head_q[hidx] <= lh_q;
								tail_q[hidx] <= lt_q;
								cur_q[hidx]  <= lc_q;
								len_q[hidx]  <= ll_q;
							end
							if (op_q == OP_CONCAT && rst_q == ST_OK) begin
								head_q[sidx] <= NIL;
								tail_q[sidx] <= NIL;
								cur_q[sidx]  <= NIL;
								len_q[sidx]  <= '0;
								use_q[sidx]  <= 1'b0;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);

	always_comb begin
		result.status     = rst_q;
		result.item_out   = rval_q ? ITEM_W'(ritem_q) : '0;
		result.item_valid = rval_q;
		result.count_out  = (hok_q && op_q != OP_FREE) ? COUNT_W'(ll_q) : '0;
		result.new_list   = rnew_q;
	end
endmodule

/* rtl/linked_list_pool_engine.sv */
// ----------------------------------------------------------------------------
// linked_list_pool_engine
// Doubly linked lists with a shared node pool and free stack, one operation
// per command transaction, one result transaction per command.
// ----------------------------------------------------------------------------
// One command is worked on at a time; cmd.ready is high only while the
// sequencer is idle. Every node access goes through the single port of each
// node RAM (item, forward link, backward link), so the cost of an operation is
// the chain of dependent reads and writes it needs. Free walks the list and
// pushes its nodes one by one; search compares node after node from the
// cursor until it finds a match or runs past the tail. The sequencer returns
// to idle as the result is loaded into the output register, and since the
// result sits there, the next command is taken while it waits.
module linked_list_pool_engine import llp_pkg::*; #(
	parameter int NUM_HEADS  = DEF_NUM_HEADS,
	parameter int NUM_NODES  = DEF_NUM_NODES,
	parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	llp_cmd_if.sink   cmd,
	llp_res_if.source res
);
	logic        start;
	logic        core_idle;
	logic        core_done;
	logic        done_ack;
	llp_cmd_t    core_cmd;
	llp_result_t core_res;
	llp_result_t res_q;
	logic        res_valid_q;

	// accept a command transaction only when the sequencer is free
	assign cmd.ready = core_idle;
	assign start     = cmd.valid & core_idle;

	always_comb begin
		core_cmd.opcode      = cmd.opcode;
		core_cmd.list_sel    = cmd.list_sel;
		core_cmd.second_list = cmd.second_list;
		core_cmd.item_value  = cmd.item_value;
	end

	// the output register can take a result when empty or being drained
	assign done_ack = !res_valid_q || res.ready;

	llp_core #(
		.NUM_HEADS (NUM_HEADS),
		.NUM_NODES (NUM_NODES),
		.ITEM_WIDTH(ITEM_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (core_cmd),
		.idle    (core_idle),
		.done    (core_done),
		.done_ack(done_ack),
		.result  (core_res)
	);

	// hold the result until the sink takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (core_done && done_ack) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done && done_ack) begin
			res_q <= core_res;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_q.status;
	assign res.item_out   = res_q.item_out;
	assign res.item_valid = res_q.item_valid;
	assign res.count_out  = res_q.count_out;
	assign res.new_list   = res_q.new_list;
endmodule
